// ----- rtl/hiba_pkg.sv -----
// hiba_pkg: widths, codes and stage types of the hash-interleaved block address translator
// no dependencies; imported by every module of the block
package hiba_pkg;

	localparam int IDX_W       = 24;
	localparam int LVL_W       = 2;
	localparam int PHYS_W      = 25;
	localparam int OFFS_W      = 40;
	localparam int TPL_W       = 2;
	localparam int HDR_W       = 32;
	localparam int BLOCK_SHIFT = 12;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 72;
	localparam int CFG_IDX_W   = 1;

	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_HASH = 1'b1;

	localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
	localparam logic [LVL_W-1:0] LVL_1 = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLES_PER_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES     = 1'd1;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] level;
	} req_t;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] level;
		logic             ge0;
		logic             ge1;
		logic [IDX_W-1:0] q0;
		logic [IDX_W-1:0] q1;
		logic [IDX_W-1:0] q2;
	} quot_t;

endpackage

// ----- rtl/hiba_cdiv.sv -----
// hiba_cdiv: unsigned division of a block index by a constant through an exact reciprocal
// depends on hiba_pkg
module hiba_cdiv import hiba_pkg::*; #(
	parameter int DIVISOR = 170
) (
	input  logic [IDX_W-1:0] idx,
	output logic [IDX_W-1:0] quot
);

	localparam int SHIFT = IDX_W + $clog2(DIVISOR);
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [IDX_W:0] RECIP = RECIP_L[IDX_W:0];

	logic [2*IDX_W+1:0] prod;
	logic [2*IDX_W+1:0] shifted;

	assign prod    = (2*IDX_W+2)'({1'b0, idx}) * (2*IDX_W+2)'(RECIP);
	assign shifted = prod >> SHIFT;
	assign quot    = shifted[IDX_W-1:0];

endmodule

// ----- rtl/hash_interleaved_block_address.sv -----
// four registered stages (index, quotients, block, offset) carry each word from s_* to m_*
// throughput: one word per cycle while m_tready is high
// a stage holds while the next one is full and stalled, so bubbles close up under backpressure
// reset: asynchronous, active low; empties the pipeline, tables_per_level = 1, header_bytes = 0
// depends on hiba_pkg and hiba_cdiv
module hash_interleaved_block_address import hiba_pkg::*; #(
	parameter int ENTRIES_PER_TABLE = 170
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [HDR_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // idx, level
	input  logic                  s_tuser,   // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // physical_block, byte_offset
);

	localparam int SPAN0 = ENTRIES_PER_TABLE;
	localparam int SPAN1 = ENTRIES_PER_TABLE * ENTRIES_PER_TABLE;
	localparam int SPAN2 = ENTRIES_PER_TABLE * ENTRIES_PER_TABLE * ENTRIES_PER_TABLE;
	localparam logic [IDX_W:0]  SPAN0_V = (IDX_W+1)'(SPAN0);
	localparam logic [IDX_W:0]  SPAN1_V = (IDX_W+1)'(SPAN1);
	localparam logic [PHYS_W-1:0] E_P   = PHYS_W'(SPAN0);
	localparam logic [PHYS_W-1:0] E2_P  = PHYS_W'(SPAN1);

	logic [TPL_W-1:0] tpl_q;
	logic [HDR_W-1:0] hdr_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	req_t              req_s1;
	quot_t             quot_s2;
	logic [PHYS_W-1:0] phys_s3;
	logic [PHYS_W-1:0] phys_s4;
	logic [OFFS_W-1:0] offs_s4;

	quot_t             quot_d;
	logic [PHYS_W-1:0] phys_d;
	logic [PHYS_W-1:0] t_p, step0, step1;
	logic [PHYS_W-1:0] q0_p, q1_p, q2_p;
	logic [PHYS_W-1:0] data_blk, hash_blk;
	logic [HDR_W-HDR_W+20:0] base_blk;
	logic [OFFS_W-1:0] base;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpl_q <= TPL_W'(1);
			hdr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLES_PER_LEVEL: tpl_q <= cfg_data[TPL_W-1:0];
				CFG_HEADER_BYTES:     hdr_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// stage handshake
	assign rdy_s4   = !vld_s4 || m_tready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: input word
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			req_s1.func  <= s_tuser;
			req_s1.idx   <= s_tdata[IDX_W-1:0];
			req_s1.level <= s_tdata[IDX_W+LVL_W-1:IDX_W];
		end
	end

	// stage 2: quotients by the three spans
	hiba_cdiv #(.DIVISOR(SPAN0)) u_div0 (.idx(req_s1.idx), .quot(quot_d.q0));
	hiba_cdiv #(.DIVISOR(SPAN1)) u_div1 (.idx(req_s1.idx), .quot(quot_d.q1));
	hiba_cdiv #(.DIVISOR(SPAN2)) u_div2 (.idx(req_s1.idx), .quot(quot_d.q2));

	assign quot_d.func  = req_s1.func;
	assign quot_d.idx   = req_s1.idx;
	assign quot_d.level = req_s1.level;
	assign quot_d.ge0   = {1'b0, req_s1.idx} >= SPAN0_V;
	assign quot_d.ge1   = {1'b0, req_s1.idx} >= SPAN1_V;

	always_ff @(posedge clk) begin
		if (rdy_s2) quot_s2 <= quot_d;
	end

	// stage 3: physical block, modulo 2^25
	assign t_p   = PHYS_W'(tpl_q);
	assign step0 = E_P + t_p;
	assign step1 = E2_P + (E_P + PHYS_W'(1)) * t_p;
	assign q0_p  = PHYS_W'(quot_s2.q0);
	assign q1_p  = PHYS_W'(quot_s2.q1);
	assign q2_p  = PHYS_W'(quot_s2.q2);

	assign data_blk = PHYS_W'(quot_s2.idx)
		+ (q0_p + PHYS_W'(1)) * t_p
		+ (quot_s2.ge0 ? (q1_p + PHYS_W'(1)) * t_p : '0)
		+ (quot_s2.ge1 ? (q2_p + PHYS_W'(1)) * t_p : '0);

	always_comb begin
		case (quot_s2.level)
			LVL_0: begin
				if (quot_s2.ge0)
					hash_blk = q0_p * step0 + (q1_p + PHYS_W'(1)) * t_p
						+ (quot_s2.ge1 ? t_p : '0);
				else
					hash_blk = '0;
			end
			LVL_1: begin
				if (quot_s2.ge1)
					hash_blk = q1_p * step1 + t_p;
				else
					hash_blk = step0;
			end
			default: hash_blk = step1;
		endcase
	end

	assign phys_d = (quot_s2.func == FUNC_DATA) ? data_blk : hash_blk;

	always_ff @(posedge clk) begin
		if (rdy_s3) phys_s3 <= phys_d;
	end

	// stage 4: byte offset from the rounded header size
	assign base_blk = {1'b0, hdr_q[HDR_W-1:BLOCK_SHIFT]} + 21'(hdr_q[BLOCK_SHIFT-1:0] != '0);
	assign base     = {(OFFS_W-BLOCK_SHIFT-21)'(0), base_blk, BLOCK_SHIFT'(0)};

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			phys_s4 <= phys_s3;
			offs_s4 <= base + {(OFFS_W-PHYS_W-BLOCK_SHIFT)'(0), phys_s3, BLOCK_SHIFT'(0)};
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {(OUT_DATA_W-OFFS_W-PHYS_W)'(0), offs_s4, phys_s4};

endmodule

// ----- rtl/hiba_checker.sv -----
// hiba_checker: port-level checks of the block address translator, bound to the top level
// depends on hiba_pkg and hash_interleaved_block_address
module hiba_checker import hiba_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// words accepted but not yet delivered
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_offs_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[PHYS_W+BLOCK_SHIFT-1:PHYS_W] == '0)
		else $error("byte offset not block aligned");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("output word without accepted input");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more words in flight than stages");

endmodule

bind hash_interleaved_block_address hiba_checker u_hiba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for hash_interleaved_block_address, bursty driver and stalling sink
// predicts physical block and byte offset per accepted word, compares against m_tdata in order
// depends on hiba_pkg and the hash_interleaved_block_address rtl
module tb_top;
	import hiba_pkg::*;

	localparam longint unsigned SPAN0 = 170;
	localparam longint unsigned SPAN1 = SPAN0 * SPAN0;
	localparam longint unsigned SPAN2 = SPAN1 * SPAN0;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PER_PHASE = 170;

	typedef struct {
		logic             func;
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] level;
	} lookup_t;

	typedef struct {
		logic [PHYS_W-1:0] phys;
		logic [OFFS_W-1:0] offs;
	} position_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [HDR_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // idx, level
	logic                  s_tuser = 1'b0; // func
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // physical_block, byte_offset

	logic [TPL_W-1:0] tables_per_level = 2'd1;
	logic [HDR_W-1:0] header_bytes = '0;

	lookup_t   pending_lookups[$];
	position_t expected_positions[$];

	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	int idle_cycles = 0;
	int err_cnt = 0;

	hash_interleaved_block_address i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic position_t block_position(lookup_t lk);
		longint unsigned t;
		longint unsigned idx;
		longint unsigned blk;
		longint unsigned span;
		longint unsigned step0;
		longint unsigned step1;
		longint unsigned base;
		position_t pos;
		t = tables_per_level;
		idx = lk.idx;
		step0 = SPAN0 + t;
		step1 = SPAN1 + (SPAN0 + 1) * t;
		if (lk.func == FUNC_DATA) begin
			blk = idx;
			for (int i = 0; i < 3; i++) begin
				span = (i == 0) ? SPAN0 : (i == 1) ? SPAN1 : SPAN2;
				blk += ((idx + span) / span) * t;
				if (idx < span)
					break;
			end
		end else if (lk.level == LVL_0) begin
			if (idx < SPAN0) begin
				blk = 0;
			end else begin
				blk = (idx / SPAN0) * step0 + (idx / SPAN1 + 1) * t;
				if (idx >= SPAN1)
					blk += t;
			end
		end else if (lk.level == LVL_1) begin
			blk = (idx < SPAN1) ? step0 : (idx / SPAN1) * step1 + t;
		end else begin
			// levels two and three both give the top table
			blk = step1;
		end
		pos.phys = blk[PHYS_W-1:0];
		base = (longint'(header_bytes) + 4095) & ~64'd4095;
		blk = base + (longint'(pos.phys) << BLOCK_SHIFT);
		pos.offs = blk[OFFS_W-1:0];
		return pos;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		longint unsigned v;
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1: v = $urandom_range(0, 400);
			2, 3: v = SPAN0 * $urandom_range(1, 400) + $urandom_range(0, 4) - 2;
			4, 5: v = SPAN1 * $urandom_range(1, 40) + $urandom_range(0, 4) - 2;
			6: v = SPAN2 * $urandom_range(1, 3) + $urandom_range(0, 4) - 2;
			7: v = (SPAN0 - 1) * $urandom_range(0, 200);
			8: v = $urandom_range(0, 1) ? 0 : 24'hFFFFFF;
			default: v = $urandom();
		endcase
		return v[IDX_W-1:0];
	endfunction

	task automatic queue_lookup(logic func, logic [IDX_W-1:0] idx, logic [LVL_W-1:0] level);
		lookup_t lk;
		lk.func = func;
		lk.idx = idx;
		lk.level = level;
		pending_lookups = {pending_lookups, lk};
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			queue_lookup(1'($urandom_range(0, 1)), pick_index(),
				LVL_W'($urandom_range(0, 3)));
	endtask

	task automatic wait_idle();
		while (pending_lookups.size() != 0 || expected_positions.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [HDR_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		if (index == CFG_TABLES_PER_LEVEL)
			tables_per_level = value[TPL_W-1:0];
		else
			header_bytes = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [TPL_W-1:0] tpl, logic [HDR_W-1:0] hdr);
		logic [HDR_W-1:0] v;
		v = $urandom();
		v[TPL_W-1:0] = tpl;
		write_reg(CFG_TABLES_PER_LEVEL, v);
		write_reg(CFG_HEADER_BYTES, hdr);
	endtask

	// sender: bursts with random gaps, holds the word until taken
	always @(posedge clk) begin
		logic nv;
		lookup_t lk;
		nv = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_positions = {expected_positions,
					block_position(pending_lookups[0])};
				void'(pending_lookups.pop_front());
			end else if (s_tvalid) begin
				nv = 1'b1;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_lookups.size() != 0) begin
					nv = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			s_tvalid <= nv;
			if (nv) begin
				lk = pending_lookups[0];
				s_tdata <= {{(IN_DATA_W-IDX_W-LVL_W){1'b0}}, lk.level, lk.idx};
				s_tuser <= lk.func;
			end
		end
	end

	// receiver: stall pattern switches between always ready, random and periodic
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		stall_phase = (stall_phase + 1) % 11;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= (stall_phase < 6);
		endcase
	end

	// result check and watchdog
	always @(posedge clk) begin
		position_t exp_pos;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_positions.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected word: phys %0h offs %0h",
						m_tdata[PHYS_W-1:0], m_tdata[PHYS_W +: OFFS_W]);
			end else begin
				exp_pos = expected_positions.pop_front();
				if (m_tdata[PHYS_W-1:0] !== exp_pos.phys
						|| m_tdata[PHYS_W +: OFFS_W] !== exp_pos.offs) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: phys exp %0h got %0h, offs exp %0h got %0h",
							exp_pos.phys, m_tdata[PHYS_W-1:0],
							exp_pos.offs, m_tdata[PHYS_W +: OFFS_W]);
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of the registers, group boundaries and all levels
		queue_lookup(FUNC_DATA, 24'd0, 2'd3);
		queue_lookup(FUNC_DATA, 24'd169, 2'd0);
		queue_lookup(FUNC_DATA, 24'd170, 2'd1);
		queue_lookup(FUNC_DATA, 24'd28899, 2'd2);
		queue_lookup(FUNC_DATA, 24'd28900, 2'd0);
		queue_lookup(FUNC_DATA, 24'd4912999, 2'd0);
		queue_lookup(FUNC_DATA, 24'd4913000, 2'd0);
		queue_lookup(FUNC_DATA, 24'hFFFFFF, 2'd3);
		queue_lookup(FUNC_HASH, 24'd0, 2'd0);
		queue_lookup(FUNC_HASH, 24'd169, 2'd0);
		queue_lookup(FUNC_HASH, 24'd170, 2'd0);
		queue_lookup(FUNC_HASH, 24'd28900, 2'd0);
		queue_lookup(FUNC_HASH, 24'hFFFFFF, 2'd0);
		queue_lookup(FUNC_HASH, 24'd28899, 2'd1);
		queue_lookup(FUNC_HASH, 24'd28900, 2'd1);
		queue_lookup(FUNC_HASH, 24'hFFFFFF, 2'd1);
		queue_lookup(FUNC_HASH, 24'd0, 2'd2);
		queue_lookup(FUNC_HASH, 24'hFFFFFF, 2'd2);
		queue_lookup(FUNC_HASH, 24'd4913000, 2'd3);
		queue_lookup(FUNC_HASH, 24'hFFFFFF, 2'd3);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();

		set_config(2'd2, 32'd0);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(2'd0, 32'd1);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(2'd3, 32'hFFFFFFFF);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(2'd1, 32'd4096);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(2'd2, 32'd4095);
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(2'd2, $urandom());
		queue_random(RANDOM_PER_PHASE);
		wait_idle();
		set_config(TPL_W'($urandom_range(0, 3)), $urandom());
		queue_random(RANDOM_PER_PHASE);
		wait_idle();

		if (err_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/hiba_pkg.sv
rtl/hiba_cdiv.sv
rtl/hash_interleaved_block_address.sv
rtl/hiba_checker.sv
dv/tb_top.sv
